[hw/rtl/upper_tri_matrix_expression_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the upper triangular matrix expression engine
// Implication checks clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef UPPER_TRI_MATRIX_EXPRESSION_MACROS_SVH
`define UPPER_TRI_MATRIX_EXPRESSION_MACROS_SVH

// same-cycle implication
`define UTME_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define UTME_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/utme_pkg.sv]
// ----------------------------------------------------------------------------
// utme_pkg
// Shared types and constants of the upper triangular matrix expression engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utme_pkg;

  localparam int DEF_MAX_SIZE = 8;
  localparam int E_W          = 16;
  localparam int AB_W         = 37;
  localparam int R_W          = 64;
  localparam int MSIZE_W      = 4;
  localparam int ALIGN_SH     = 8;
  localparam int PADDR_W      = 3;

  localparam logic [MSIZE_W-1:0] MSIZE_RST  = 4'd8;
  localparam logic [PADDR_W-1:0] ADDR_MSIZE = 3'd0;

  typedef enum logic [1:0] {
    REQ_WR_A = 2'd0,
    REQ_WR_B = 2'd1,
    REQ_COMP = 2'd2,
    REQ_RD   = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTREADY = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic shift;
    logic to_ab;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

[hw/rtl/utme_store.sv]
// ----------------------------------------------------------------------------
// utme_store
// Matrix memories: A (two read ports), B, A*B and result, with registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utme_store #(
  parameter int MAX_SIZE = utme_pkg::DEF_MAX_SIZE
) (
  input  logic                                clk,
  input  logic                                a_we,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] a_waddr,
  input  logic signed [utme_pkg::E_W-1:0]     a_wdata,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] a_raddr0,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] a_raddr1,
  output logic signed [utme_pkg::E_W-1:0]     a_rdata0,
  output logic signed [utme_pkg::E_W-1:0]     a_rdata1,
  input  logic                                b_we,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] b_waddr,
  input  logic signed [utme_pkg::E_W-1:0]     b_wdata,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] b_raddr,
  output logic signed [utme_pkg::E_W-1:0]     b_rdata,
  input  logic                                ab_we,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] ab_waddr,
  input  logic signed [utme_pkg::AB_W-1:0]    ab_wdata,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] ab_raddr,
  output logic signed [utme_pkg::AB_W-1:0]    ab_rdata,
  input  logic                                r_we,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] r_waddr,
  input  logic signed [utme_pkg::R_W-1:0]     r_wdata,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] r_raddr,
  output logic signed [utme_pkg::R_W-1:0]     r_rdata
);

  localparam int CELLS = MAX_SIZE * MAX_SIZE;

  logic signed [utme_pkg::E_W-1:0]  a_mem  [CELLS];
  logic signed [utme_pkg::E_W-1:0]  b_mem  [CELLS];
  logic signed [utme_pkg::AB_W-1:0] ab_mem [CELLS];
  logic signed [utme_pkg::R_W-1:0]  r_mem  [CELLS];

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= a_wdata;
    end
    a_rdata0 <= a_mem[a_raddr0];
    a_rdata1 <= a_mem[a_raddr1];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= b_wdata;
    end
    b_rdata <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (ab_we) begin
      ab_mem[ab_waddr] <= ab_wdata;
    end
    ab_rdata <= ab_mem[ab_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[r_waddr] <= r_wdata;
    end
    r_rdata <= r_mem[r_raddr];
  end

endmodule

[hw/rtl/utme_seq.sv]
// ----------------------------------------------------------------------------
// utme_seq
// Compute sequencer: walks A*B, then A*B*B^T + (A^T*A << 8), through one
// pipelined multiply-accumulate (read, multiply, accumulate/write back).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "upper_tri_matrix_expression_macros.svh"

module utme_seq #(
  parameter int MAX_SIZE = utme_pkg::DEF_MAX_SIZE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic [$clog2(MAX_SIZE)-1:0]         n1,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] a_raddr0,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] a_raddr1,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] b_raddr,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] ab_raddr,
  input  logic signed [utme_pkg::E_W-1:0]     a_rdata0,
  input  logic signed [utme_pkg::E_W-1:0]     a_rdata1,
  input  logic signed [utme_pkg::E_W-1:0]     b_rdata,
  input  logic signed [utme_pkg::AB_W-1:0]    ab_rdata,
  output logic                                ab_we,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] ab_waddr,
  output logic signed [utme_pkg::AB_W-1:0]    ab_wdata,
  output logic                                r_we,
  output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] r_waddr,
  output logic signed [utme_pkg::R_W-1:0]     r_wdata,
  output utme_pkg::seq_stat_t                 stat
);

  localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int IW = $clog2(MAX_SIZE);
  localparam int PW = utme_pkg::AB_W + utme_pkg::E_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_P1   = 5'b00010,
    S_D1   = 5'b00100,
    S_P2   = 5'b01000,
    S_D2   = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    addr_of = AW'(32'(r) * MAX_SIZE + 32'(c));
  endfunction

  state_t              state, state_next;
  logic [IW-1:0]       i, j, k, i_next, j_next, k_next, m;
  logic                sub, sub_next;
  logic                done;
  logic                drained;
  utme_pkg::mac_ctl_t  ctl0, ctl1, ctl2;
  logic [IW-1:0]       wi1, wj1, wi2, wj2;
  logic signed [utme_pkg::AB_W-1:0] x;
  logic signed [utme_pkg::E_W-1:0]  y;
  logic signed [PW-1:0]             prod;
  logic signed [utme_pkg::R_W-1:0]  term, acc, acc_sum;

  assign m       = (i < j) ? i : j;
  assign drained = !ctl1.valid && !ctl2.valid;

  // issue
  always_comb begin
    ctl0       = '0;
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    sub_next   = sub;
    case (state)
      S_IDLE: begin
        if (go) begin
          state_next = S_P1;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          sub_next   = 1'b0;
        end
      end
      S_P1: begin
        ctl0.valid = 1'b1;
        ctl0.to_ab = 1'b1;
        ctl0.first = (k == i);
        ctl0.last  = (k == n1);
        if (k == n1) begin
          if (j == n1) begin
            if (i == n1) begin
              state_next = S_D1;
            end else begin
              i_next = i + 1'b1;
              j_next = '0;
              k_next = i + 1'b1;
            end
          end else begin
            j_next = j + 1'b1;
            k_next = i;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_D1: begin
        if (drained) begin
          state_next = S_P2;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          sub_next   = 1'b0;
        end
      end
      S_P2: begin
        ctl0.valid = 1'b1;
        ctl0.shift = sub;
        ctl0.first = !sub && (k == '0);
        ctl0.last  = sub && (k == m);
        if (!sub) begin
          if (k == n1) begin
            sub_next = 1'b1;
            k_next   = '0;
          end else begin
            k_next = k + 1'b1;
          end
        end else if (k == m) begin
          sub_next = 1'b0;
          k_next   = '0;
          if (j == n1) begin
            j_next = '0;
            if (i == n1) begin
              state_next = S_D2;
            end else begin
              i_next = i + 1'b1;
            end
          end else begin
            j_next = j + 1'b1;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_D2: begin
        if (drained) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign a_raddr0 = (state == S_P1) ? addr_of(i, k) : addr_of(k, i);
  assign a_raddr1 = addr_of(k, j);
  assign b_raddr  = (state == S_P1) ? addr_of(k, j) : addr_of(j, k);
  assign ab_raddr = addr_of(i, k);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      sub   <= 1'b0;
      done  <= 1'b0;
      ctl1  <= '0;
      ctl2  <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      sub   <= sub_next;
      done  <= (state == S_D2) && drained;
      ctl1  <= ctl0;
      ctl2  <= ctl1;
    end
  end

  // multiply
  always_comb begin
    if (ctl1.to_ab || ctl1.shift) begin
      x = {{(utme_pkg::AB_W-utme_pkg::E_W){a_rdata0[utme_pkg::E_W-1]}}, a_rdata0};
    end else begin
      x = ab_rdata;
    end
    y = ctl1.shift ? a_rdata1 : b_rdata;
  end

  always_ff @(posedge clk) begin
    wi1  <= i;
    wj1  <= j;
    wi2  <= wi1;
    wj2  <= wj1;
    prod <= x * y;
  end

  // accumulate and write back
  always_comb begin
    term = {{(utme_pkg::R_W-PW){prod[PW-1]}}, prod};
    if (ctl2.shift) begin
      term = term <<< utme_pkg::ALIGN_SH;
    end
    acc_sum = (ctl2.first ? '0 : acc) + term;
  end

  always_ff @(posedge clk) begin
    if (ctl2.valid) begin
      acc <= acc_sum;
    end
  end

  assign ab_we    = ctl2.valid && ctl2.last && ctl2.to_ab;
  assign r_we     = ctl2.valid && ctl2.last && !ctl2.to_ab;
  assign ab_waddr = addr_of(wi2, wj2);
  assign r_waddr  = addr_of(wi2, wj2);
  assign ab_wdata = acc_sum[utme_pkg::AB_W-1:0];
  assign r_wdata  = acc_sum;

  assign stat.busy = (state != S_IDLE) || done;
  assign stat.done = done;

  `UTME_ASSERT_SAME(a_done_idle, done, state == S_IDLE, "done outside idle")
  `UTME_ASSERT_SAME(a_k_bound, (state == S_P1) || (state == S_P2), k <= n1, "k past size")
  `UTME_ASSERT_NEXT(a_drain_done, (state == S_D2) && drained, done, "no done after drain")
  `UTME_ASSERT_SAME(a_p2_last, ctl2.valid && ctl2.last && !ctl2.to_ab, ctl2.shift,
                    "result write outside the A^T*A pass")

endmodule

[hw/rtl/upper_tri_matrix_expression.sv]
// Latency: load and read beats give their result in the cycle after acceptance.
// Throughput: loads and reads one per cycle while busy is low; compute holds busy
//   until the single multiply-accumulate pipeline has walked both passes and
//   drained; its result follows busy.
// Reset: synchronous rst clears control, result-ready flag and matrix_size to 8;
//   matrix memories are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// upper_tri_matrix_expression
// Command decode, configuration port and result register around the matrix
// memories and the compute sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upper_tri_matrix_expression #(
  parameter int MAX_SIZE = utme_pkg::DEF_MAX_SIZE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type,
  input  logic [2:0]                          row,
  input  logic [2:0]                          col,
  input  logic signed [utme_pkg::E_W-1:0]     value,
  output logic                                valid,
  output logic signed [utme_pkg::R_W-1:0]     read_value,
  output logic [1:0]                          status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [utme_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int IW = $clog2(MAX_SIZE);
  localparam int NW = $clog2(MAX_SIZE + 1);

  logic [utme_pkg::MSIZE_W-1:0] msize;
  logic [NW-1:0]                n;
  logic [IW-1:0]                n1;
  logic                         accept, in_range, ready, rd_ok;
  logic [1:0]                   status_next;
  logic [AW-1:0]                cmd_addr;
  utme_pkg::req_t               req;
  utme_pkg::seq_stat_t          stat;

  logic [AW-1:0]                a_raddr0, a_raddr1, b_raddr, ab_raddr;
  logic signed [utme_pkg::E_W-1:0]  a_rdata0, a_rdata1, b_rdata;
  logic signed [utme_pkg::AB_W-1:0] ab_rdata, ab_wdata;
  logic signed [utme_pkg::R_W-1:0]  r_rdata, r_wdata;
  logic                         ab_we, r_we;
  logic [AW-1:0]                ab_waddr, r_waddr;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == utme_pkg::ADDR_MSIZE) ? 32'(msize) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      msize <= utme_pkg::MSIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr == utme_pkg::ADDR_MSIZE)) begin
      msize <= pwdata[utme_pkg::MSIZE_W-1:0];
    end
  end

  always_comb begin
    if (msize == '0) begin
      n = NW'(1);
    end else if (32'(msize) > MAX_SIZE) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(msize);
    end
  end

  assign n1 = IW'(n - 1'b1);

  // command decode
  assign req      = utme_pkg::req_t'(req_type);
  assign accept   = start && !busy;
  assign in_range = (32'(row) < 32'(n)) && (32'(col) < 32'(n));
  assign cmd_addr = AW'(32'(row) * MAX_SIZE + 32'(col));
  assign busy     = stat.busy;

  always_comb begin
    if (req == utme_pkg::REQ_COMP) begin
      status_next = utme_pkg::ST_OK;
    end else if (!in_range) begin
      status_next = utme_pkg::ST_RANGE;
    end else if ((req == utme_pkg::REQ_RD) && !ready) begin
      status_next = utme_pkg::ST_NOTREADY;
    end else begin
      status_next = utme_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rd_ok <= 1'b0;
      ready <= 1'b0;
    end else begin
      valid <= (accept && (req != utme_pkg::REQ_COMP)) || stat.done;
      rd_ok <= accept && (req == utme_pkg::REQ_RD) && in_range && ready;
      if (stat.done) begin
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      status <= utme_pkg::ST_OK;
    end else if (accept) begin
      status <= status_next;
    end
  end

  assign read_value = rd_ok ? r_rdata : '0;

  utme_store #(.MAX_SIZE(MAX_SIZE)) u_store (
    .clk      (clk),
    .a_we     (accept && (req == utme_pkg::REQ_WR_A) && in_range),
    .a_waddr  (cmd_addr),
    .a_wdata  (value),
    .a_raddr0 (a_raddr0),
    .a_raddr1 (a_raddr1),
    .a_rdata0 (a_rdata0),
    .a_rdata1 (a_rdata1),
    .b_we     (accept && (req == utme_pkg::REQ_WR_B) && in_range),
    .b_waddr  (cmd_addr),
    .b_wdata  (value),
    .b_raddr  (b_raddr),
    .b_rdata  (b_rdata),
    .ab_we    (ab_we),
    .ab_waddr (ab_waddr),
    .ab_wdata (ab_wdata),
    .ab_raddr (ab_raddr),
    .ab_rdata (ab_rdata),
    .r_we     (r_we),
    .r_waddr  (r_waddr),
    .r_wdata  (r_wdata),
    .r_raddr  (cmd_addr),
    .r_rdata  (r_rdata)
  );

  utme_seq #(.MAX_SIZE(MAX_SIZE)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .go       (accept && (req == utme_pkg::REQ_COMP)),
    .n1       (n1),
    .a_raddr0 (a_raddr0),
    .a_raddr1 (a_raddr1),
    .b_raddr  (b_raddr),
    .ab_raddr (ab_raddr),
    .a_rdata0 (a_rdata0),
    .a_rdata1 (a_rdata1),
    .b_rdata  (b_rdata),
    .ab_rdata (ab_rdata),
    .ab_we    (ab_we),
    .ab_waddr (ab_waddr),
    .ab_wdata (ab_wdata),
    .r_we     (r_we),
    .r_waddr  (r_waddr),
    .r_wdata  (r_wdata),
    .stat     (stat)
  );

endmodule
